FILE: rtl/ccirc_pkg.sv
// ----------------------------------------------------------------------------
// ccirc_pkg
// shared constants and types for the circumcircle pipeline
// ----------------------------------------------------------------------------
package ccirc_pkg;

    localparam int COORD_BITS_DEF = 11;
    localparam int OUT_BITS       = 32;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_COLLINEAR = 2'd1,
        ST_RANGE     = 2'd2
    } t_status;

endpackage

FILE: rtl/circumcircle_from_three_points.sv
// ----------------------------------------------------------------------------
// circumcircle_from_three_points
// centre, radius and winding sense of the circle through three integer points
// ----------------------------------------------------------------------------
// A request is taken on every cycle that start is high; busy never rises, so a
// new triple may follow every cycle. Each request gives one result, in request
// order, marked by o_valid for a single cycle. The receiver cannot stall the
// block, so the result must be captured in that cycle. The pipeline runs
// through the restoring dividers, one quotient bit per stage over
// 3*COORD_BITS+4 stages, and through the 32-stage square root, one root bit
// per stage. The centre is truncated toward zero and clamped to 32 bits
// (status out of range); collinear or coincident points give status collinear
// with all other fields zero.
module circumcircle_from_three_points
#(
    parameter int COORD_BITS = ccirc_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [COORD_BITS-1:0]          i_x1,
    input  logic signed [COORD_BITS-1:0]          i_y1,
    input  logic signed [COORD_BITS-1:0]          i_x2,
    input  logic signed [COORD_BITS-1:0]          i_y2,
    input  logic signed [COORD_BITS-1:0]          i_x3,
    input  logic signed [COORD_BITS-1:0]          i_y3,
    output logic                                  o_valid,
    output logic signed [ccirc_pkg::OUT_BITS-1:0] o_center_x,
    output logic signed [ccirc_pkg::OUT_BITS-1:0] o_center_y,
    output logic        [ccirc_pkg::OUT_BITS-1:0] o_radius,
    output logic                                  o_clockwise,
    output logic        [1:0]                     o_status
);

    import ccirc_pkg::*;

    // widths follow from the coordinate width
    localparam int CW  = COORD_BITS;
    localparam int DW  = CW + 1;          // coordinate differences
    localparam int SW  = 2 * CW + 1;      // x*x + y*y, signed
    localparam int AW  = 2 * CW + 3;      // determinant a
    localparam int BW  = 3 * CW + 4;      // terms b and c
    localparam int XW  = 2 * DW + 1;      // cross product terms
    localparam int QW  = BW;              // quotient bits, one per stage
    localparam int RW  = AW + 2;          // divider remainder
    localparam int MW  = (QW > OUT_BITS + 1) ? QW : OUT_BITS + 1;
    localparam int OW  = OUT_BITS;
    localparam int PW  = 2 * OW;          // squared distance
    localparam int QRW = OW + 3;          // square root remainder
    localparam int LAT = QW + 41;         // request to result strobe

    localparam logic [MW-1:0] POS_LIM = MW'({1'b0, {(OW-1){1'b1}}});
    localparam logic [MW-1:0] NEG_LIM = MW'({1'b1, {(OW-1){1'b0}}});
    localparam logic [OW-1:0] SAT_MAX = {1'b0, {(OW-1){1'b1}}};
    localparam logic [OW-1:0] SAT_MIN = {1'b1, {(OW-1){1'b0}}};

    // the pipeline never holds a request back
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // stage 1: squares, differences, cross term of a
    // ------------------------------------------------------------------
    logic                 r1_vld;
    logic signed [SW-1:0] r1_s1, r1_s2, r1_s3;
    logic signed [DW-1:0] r1_dy32, r1_dy13, r1_dy21, r1_dx23, r1_dx31, r1_dx12;
    logic signed [AW-1:0] r1_p23;
    logic signed [CW-1:0] r1_x1, r1_y1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_s1   <= SW'(i_x1) * SW'(i_x1) + SW'(i_y1) * SW'(i_y1);
        r1_s2   <= SW'(i_x2) * SW'(i_x2) + SW'(i_y2) * SW'(i_y2);
        r1_s3   <= SW'(i_x3) * SW'(i_x3) + SW'(i_y3) * SW'(i_y3);
        r1_dy32 <= DW'(i_y3) - DW'(i_y2);
        r1_dy13 <= DW'(i_y1) - DW'(i_y3);
        r1_dy21 <= DW'(i_y2) - DW'(i_y1);
        r1_dx23 <= DW'(i_x2) - DW'(i_x3);
        r1_dx31 <= DW'(i_x3) - DW'(i_x1);
        r1_dx12 <= DW'(i_x1) - DW'(i_x2);
        r1_p23  <= AW'(i_x2) * AW'(i_y3) - AW'(i_x3) * AW'(i_y2);
        r1_x1   <= i_x1;
        r1_y1   <= i_y1;
    end

    // ------------------------------------------------------------------
    // stage 2: products of b, c, a and the cross product
    // ------------------------------------------------------------------
    logic                 r2_vld;
    logic signed [BW-1:0] r2_bp1, r2_bp2, r2_bp3, r2_cp1, r2_cp2, r2_cp3;
    logic signed [AW-1:0] r2_ap1, r2_ap2, r2_p23;
    logic signed [XW-1:0] r2_cr1, r2_cr2;
    logic signed [CW-1:0] r2_x1, r2_y1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_bp1 <= BW'(r1_s1) * BW'(r1_dy32);
        r2_bp2 <= BW'(r1_s2) * BW'(r1_dy13);
        r2_bp3 <= BW'(r1_s3) * BW'(r1_dy21);
        r2_cp1 <= BW'(r1_s1) * BW'(r1_dx23);
        r2_cp2 <= BW'(r1_s2) * BW'(r1_dx31);
        r2_cp3 <= BW'(r1_s3) * BW'(r1_dx12);
        r2_ap1 <= AW'(r1_x1) * AW'(r1_dy32);
        r2_ap2 <= AW'(r1_y1) * AW'(r1_dx23);
        r2_p23 <= r1_p23;
        // cross = (y2-y1)*(x3-x2) - (x2-x1)*(y3-y2) = dx12*dy32 - dy21*dx23
        r2_cr1 <= XW'(r1_dx12) * XW'(r1_dy32);
        r2_cr2 <= XW'(r1_dy21) * XW'(r1_dx23);
        r2_x1  <= r1_x1;
        r2_y1  <= r1_y1;
    end

    // ------------------------------------------------------------------
    // stage 3: sums
    // ------------------------------------------------------------------
    logic                 r3_vld;
    logic signed [AW-1:0] r3_a;
    logic signed [BW-1:0] r3_b, r3_c;
    logic                 r3_cw;
    logic signed [CW-1:0] r3_x1, r3_y1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_a  <= r2_p23 - r2_ap1 - r2_ap2;
        r3_b  <= r2_bp1 + r2_bp2 + r2_bp3;
        r3_c  <= r2_cp1 + r2_cp2 + r2_cp3;
        r3_cw <= (r2_cr1 > r2_cr2);
        r3_x1 <= r2_x1;
        r3_y1 <= r2_y1;
    end

    // ------------------------------------------------------------------
    // stage 4 and divider: magnitudes of -b/(2a), -c/(2a) by restoring
    // division, one quotient bit per stage; sign applied afterwards so the
    // quotient truncates toward zero
    // ------------------------------------------------------------------
    logic                 r_dv_vld  [0:QW];
    logic [BW-1:0]        r_dv_nx   [0:QW];
    logic [BW-1:0]        r_dv_ny   [0:QW];
    logic [RW-1:0]        r_dv_rx   [0:QW];
    logic [RW-1:0]        r_dv_ry   [0:QW];
    logic [AW:0]          r_dv_d    [0:QW];
    logic                 r_dv_negx [0:QW];
    logic                 r_dv_negy [0:QW];
    logic                 r_dv_col  [0:QW];
    logic                 r_dv_cw   [0:QW];
    logic signed [CW-1:0] r_dv_x1   [0:QW];
    logic signed [CW-1:0] r_dv_y1   [0:QW];

    logic [AW-1:0] n_abs_a;

    always_comb begin
        n_abs_a = r3_a[AW-1] ? AW'(-r3_a) : AW'(r3_a);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else begin
            r_dv_vld[0] <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_nx[0]   <= r3_b[BW-1] ? BW'(-r3_b) : BW'(r3_b);
        r_dv_ny[0]   <= r3_c[BW-1] ? BW'(-r3_c) : BW'(r3_c);
        r_dv_rx[0]   <= '0;
        r_dv_ry[0]   <= '0;
        r_dv_d[0]    <= {n_abs_a, 1'b0};
        // -b/(2a) is negative when b and a share a sign
        r_dv_negx[0] <= (r3_b[BW-1] == r3_a[AW-1]);
        r_dv_negy[0] <= (r3_c[BW-1] == r3_a[AW-1]);
        r_dv_col[0]  <= (r3_a == '0);
        r_dv_cw[0]   <= r3_cw;
        r_dv_x1[0]   <= r3_x1;
        r_dv_y1[0]   <= r3_y1;
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [RW-1:0] n_tx, n_ty;
        logic [RW-1:0] n_rx, n_ry;
        logic          n_qx, n_qy;

        always_comb begin
            n_tx = {r_dv_rx[k][RW-2:0], r_dv_nx[k][BW-1]};
            n_ty = {r_dv_ry[k][RW-2:0], r_dv_ny[k][BW-1]};
            n_qx = (n_tx >= RW'(r_dv_d[k]));
            n_qy = (n_ty >= RW'(r_dv_d[k]));
            n_rx = n_qx ? n_tx - RW'(r_dv_d[k]) : n_tx;
            n_ry = n_qy ? n_ty - RW'(r_dv_d[k]) : n_ty;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k+1] <= 1'b0;
            end else begin
                r_dv_vld[k+1] <= r_dv_vld[k];
            end
        end

        // numerator shifts out at the top while quotient bits enter below
        always_ff @(posedge i_clk) begin
            r_dv_nx[k+1]   <= {r_dv_nx[k][BW-2:0], n_qx};
            r_dv_ny[k+1]   <= {r_dv_ny[k][BW-2:0], n_qy};
            r_dv_rx[k+1]   <= n_rx;
            r_dv_ry[k+1]   <= n_ry;
            r_dv_d[k+1]    <= r_dv_d[k];
            r_dv_negx[k+1] <= r_dv_negx[k];
            r_dv_negy[k+1] <= r_dv_negy[k];
            r_dv_col[k+1]  <= r_dv_col[k];
            r_dv_cw[k+1]   <= r_dv_cw[k];
            r_dv_x1[k+1]   <= r_dv_x1[k];
            r_dv_y1[k+1]   <= r_dv_y1[k];
        end
    end

    // ------------------------------------------------------------------
    // stage 5: sign and clamp to 32 bits
    // ------------------------------------------------------------------
    logic                 r5_vld, r5_col, r5_cw, r5_sat;
    logic [OW-1:0]        r5_cx, r5_cy;
    logic signed [CW-1:0] r5_x1, r5_y1;
    logic [MW-1:0]        n_mx, n_my;
    logic                 n_satx, n_saty;
    logic [OW-1:0]        n_cx, n_cy;

    always_comb begin
        n_mx   = MW'(r_dv_nx[QW]);
        n_my   = MW'(r_dv_ny[QW]);
        n_satx = r_dv_negx[QW] ? (n_mx > NEG_LIM) : (n_mx > POS_LIM);
        n_saty = r_dv_negy[QW] ? (n_my > NEG_LIM) : (n_my > POS_LIM);
        if (n_satx) begin
            n_cx = r_dv_negx[QW] ? SAT_MIN : SAT_MAX;
        end else begin
            n_cx = r_dv_negx[QW] ? OW'(-n_mx) : OW'(n_mx);
        end
        if (n_saty) begin
            n_cy = r_dv_negy[QW] ? SAT_MIN : SAT_MAX;
        end else begin
            n_cy = r_dv_negy[QW] ? OW'(-n_my) : OW'(n_my);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r_dv_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        r5_cx  <= n_cx;
        r5_cy  <= n_cy;
        r5_sat <= n_satx | n_saty;
        r5_col <= r_dv_col[QW];
        r5_cw  <= r_dv_cw[QW];
        r5_x1  <= r_dv_x1[QW];
        r5_y1  <= r_dv_y1[QW];
    end

    // ------------------------------------------------------------------
    // stage 6: distance components from centre to first point
    // ------------------------------------------------------------------
    logic                   r6_vld, r6_col, r6_cw, r6_sat;
    logic [OW-1:0]          r6_cx, r6_cy, r6_dx, r6_dy;
    logic signed [OW:0]     n_ddx, n_ddy;

    always_comb begin
        n_ddx = (OW+1)'(signed'(r5_cx)) - (OW+1)'(r5_x1);
        n_ddy = (OW+1)'(signed'(r5_cy)) - (OW+1)'(r5_y1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
    end

    // magnitude stays below 2^32 since the centre is clamped to 32 bits
    always_ff @(posedge i_clk) begin
        r6_dx  <= n_ddx[OW] ? OW'(-n_ddx) : OW'(n_ddx);
        r6_dy  <= n_ddy[OW] ? OW'(-n_ddy) : OW'(n_ddy);
        r6_cx  <= r5_cx;
        r6_cy  <= r5_cy;
        r6_sat <= r5_sat;
        r6_col <= r5_col;
        r6_cw  <= r5_cw;
    end

    // ------------------------------------------------------------------
    // stage 7: squares, stage 8: sum
    // ------------------------------------------------------------------
    logic          r7_vld, r7_col, r7_cw, r7_sat;
    logic [OW-1:0] r7_cx, r7_cy;
    logic [PW-1:0] r7_dx2, r7_dy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r7_dx2 <= PW'(r6_dx) * PW'(r6_dx);
        r7_dy2 <= PW'(r6_dy) * PW'(r6_dy);
        r7_cx  <= r6_cx;
        r7_cy  <= r6_cy;
        r7_sat <= r6_sat;
        r7_col <= r6_col;
        r7_cw  <= r6_cw;
    end

    // ------------------------------------------------------------------
    // square root: one root bit per stage, two radicand bits consumed
    // ------------------------------------------------------------------
    logic           r_sq_vld [0:OW];
    logic [PW-1:0]  r_sq_n   [0:OW];
    logic [QRW-1:0] r_sq_rem [0:OW];
    logic [OW-1:0]  r_sq_rt  [0:OW];
    logic [OW-1:0]  r_sq_cx  [0:OW];
    logic [OW-1:0]  r_sq_cy  [0:OW];
    logic           r_sq_sat [0:OW];
    logic           r_sq_col [0:OW];
    logic           r_sq_cw  [0:OW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else begin
            r_sq_vld[0] <= r7_vld;
        end
    end

    // sum of squares stays below 2^64
    always_ff @(posedge i_clk) begin
        r_sq_n[0]   <= r7_dx2 + r7_dy2;
        r_sq_rem[0] <= '0;
        r_sq_rt[0]  <= '0;
        r_sq_cx[0]  <= r7_cx;
        r_sq_cy[0]  <= r7_cy;
        r_sq_sat[0] <= r7_sat;
        r_sq_col[0] <= r7_col;
        r_sq_cw[0]  <= r7_cw;
    end

    for (genvar j = 0; j < OW; j++) begin : g_sqrt
        logic [QRW-1:0] n_t, n_trial, n_rem;
        logic           n_bit;

        always_comb begin
            n_t     = {r_sq_rem[j][QRW-3:0], r_sq_n[j][PW-1:PW-2]};
            n_trial = {1'b0, r_sq_rt[j], 2'b01};
            n_bit   = (n_t >= n_trial);
            n_rem   = n_bit ? n_t - n_trial : n_t;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[j+1] <= 1'b0;
            end else begin
                r_sq_vld[j+1] <= r_sq_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq_n[j+1]   <= {r_sq_n[j][PW-3:0], 2'b00};
            r_sq_rem[j+1] <= n_rem;
            r_sq_rt[j+1]  <= {r_sq_rt[j][OW-2:0], n_bit};
            r_sq_cx[j+1]  <= r_sq_cx[j];
            r_sq_cy[j+1]  <= r_sq_cy[j];
            r_sq_sat[j+1] <= r_sq_sat[j];
            r_sq_col[j+1] <= r_sq_col[j];
            r_sq_cw[j+1]  <= r_sq_cw[j];
        end
    end

    // ------------------------------------------------------------------
    // output register: collinear points override every field
    // ------------------------------------------------------------------
    logic          r_out_vld;
    logic [OW-1:0] r_out_cx, r_out_cy, r_out_rad;
    logic          r_out_cw;
    t_status       r_out_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_sq_vld[OW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sq_col[OW]) begin
            r_out_cx  <= '0;
            r_out_cy  <= '0;
            r_out_rad <= '0;
            r_out_cw  <= 1'b0;
            r_out_st  <= ST_COLLINEAR;
        end else begin
            r_out_cx  <= r_sq_cx[OW];
            r_out_cy  <= r_sq_cy[OW];
            r_out_rad <= r_sq_rt[OW];
            r_out_cw  <= r_sq_cw[OW];
            r_out_st  <= r_sq_sat[OW] ? ST_RANGE : ST_OK;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_center_x  = signed'(r_out_cx);
    assign o_center_y  = signed'(r_out_cy);
    assign o_radius    = r_out_rad;
    assign o_clockwise = r_out_cw;
    assign o_status    = r_out_st;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_valid)
        else $error("result strobe missing after fixed latency");

    a_collinear_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_COLLINEAR) |->
            (o_center_x == '0 && o_center_y == '0 && o_radius == '0 && !o_clockwise))
        else $error("collinear result with nonzero fields");

    a_range_clamped : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_RANGE) |->
            (o_center_x == signed'(SAT_MAX) || o_center_x == signed'(SAT_MIN) ||
             o_center_y == signed'(SAT_MAX) || o_center_y == signed'(SAT_MIN)))
        else $error("out of range status without a clamped centre");

endmodule

FILE: tb/tb_circumcircle_from_three_points.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circumcircle_from_three_points
// self-checking bench: directed and random point triples, results predicted
// in the bench and compared field by field in request order
// ----------------------------------------------------------------------------

// expected results, oldest first
class circle_board;
    typedef struct {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic        [31:0] rad;
        logic               cw;
        ccirc_pkg::t_status st;
    } t_circle;

    t_circle pending[$];
    int      errors;

    function new();
        errors = 0;
    endfunction

    function longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function longint clip32(longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // note one accepted request and queue its circle
    function void note_request(longint x1, longint y1, longint x2, longint y2,
                               longint x3, longint y3);
        longint  s1, s2, s3, a, b, c, cr, cx, cy, dx, dy;
        bit      sat;
        t_circle e;
        sat = 0;
        s1 = x1 * x1 + y1 * y1;
        s2 = x2 * x2 + y2 * y2;
        s3 = x3 * x3 + y3 * y3;
        a  = x1 * (y2 - y3) - y1 * (x2 - x3) + x2 * y3 - x3 * y2;
        b  = s1 * (y3 - y2) + s2 * (y1 - y3) + s3 * (y2 - y1);
        c  = s1 * (x2 - x3) + s2 * (x3 - x1) + s3 * (x1 - x2);
        cr = (y2 - y1) * (x3 - x2) - (x2 - x1) * (y3 - y2);
        if (a == 0) begin
            e.cx = '0; e.cy = '0; e.rad = '0; e.cw = 1'b0;
            e.st = ccirc_pkg::ST_COLLINEAR;
        end else begin
            cx = clip32((-b) / (2 * a), sat);
            cy = clip32((-c) / (2 * a), sat);
            dx = (cx >= x1) ? cx - x1 : x1 - cx;
            dy = (cy >= y1) ? cy - y1 : y1 - cy;
            e.cx  = cx[31:0];
            e.cy  = cy[31:0];
            e.rad = 32'(floor_sqrt(longint'(dx * dx) + longint'(dy * dy)));
            e.cw  = (cr > 0);
            e.st  = sat ? ccirc_pkg::ST_RANGE : ccirc_pkg::ST_OK;
        end
        pending.insert(pending.size(), e);
    endfunction

    function void check_result(logic signed [31:0] cx, logic signed [31:0] cy,
                               logic [31:0] rad, logic cw, logic [1:0] st);
        t_circle e;
        if (pending.size() == 0) begin
            $error("result with no request pending");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (cx !== e.cx) begin
            $error("center_x expected %0d got %0d", e.cx, cx); errors++;
        end
        if (cy !== e.cy) begin
            $error("center_y expected %0d got %0d", e.cy, cy); errors++;
        end
        if (rad !== e.rad) begin
            $error("radius expected %0d got %0d", e.rad, rad); errors++;
        end
        if (cw !== e.cw) begin
            $error("clockwise expected %0d got %0d", e.cw, cw); errors++;
        end
        if (st !== e.st) begin
            $error("status expected %0d got %0d", e.st, st); errors++;
        end
    endfunction
endclass

module tb_circumcircle_from_three_points;
    import ccirc_pkg::*;

    localparam int CB       = COORD_BITS_DEF;
    localparam int LATENCY  = 3 * CB + 45;
    localparam int WD_LIMIT = 20 * LATENCY + 2000;
    localparam int N_RANDOM = 600;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    logic busy;
    logic signed [CB-1:0] i_x1 = 0, i_y1 = 0, i_x2 = 0, i_y2 = 0, i_x3 = 0, i_y3 = 0;
    logic o_valid;
    logic signed [31:0] o_center_x, o_center_y;
    logic [31:0] o_radius;
    logic o_clockwise;
    logic [1:0] o_status;

    circle_board board = new();
    int idle_pct = 0;        // sender gap probability, percent
    int quiet_cycles = 0;    // watchdog: cycles without any accepted transfer

    always #5 i_clk = ~i_clk;

    circumcircle_from_three_points #(.COORD_BITS(CB)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_x1(i_x1), .i_y1(i_y1), .i_x2(i_x2), .i_y2(i_y2),
        .i_x3(i_x3), .i_y3(i_y3),
        .o_valid(o_valid), .o_center_x(o_center_x), .o_center_y(o_center_y),
        .o_radius(o_radius), .o_clockwise(o_clockwise), .o_status(o_status)
    );

    // result capture and watchdog; outputs are sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            board.check_result(o_center_x, o_center_y, o_radius, o_clockwise, o_status);
        if (i_rst_n && ((start && !busy) || o_valid))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // drive one request and hold it until busy is low at an edge;
    // start stays high into the next request when no gap is drawn
    task automatic send_request(int x1, int y1, int x2, int y2, int x3, int y3);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        start <= 1;
        i_x1 <= CB'(x1); i_y1 <= CB'(y1); i_x2 <= CB'(x2);
        i_y2 <= CB'(y2); i_x3 <= CB'(x3); i_y3 <= CB'(y3);
        do @(posedge i_clk); while (busy);
        board.note_request(i_x1, i_y1, i_x2, i_y2, i_x3, i_y3);
    endtask

    function automatic int rand_coord();
        return $signed(CB'($urandom));
    endfunction

    // mostly well-formed triangles of varied size; some degenerate ones
    task automatic send_random();
        int x1, y1, span;
        x1 = rand_coord();
        y1 = rand_coord();
        case ($urandom_range(9))
            0: send_request(x1, y1, x1, y1, rand_coord(), rand_coord());
            1: send_request(x1, y1, x1 + 1, y1 + 1, x1 + 2, y1 + 2);
            2: send_request(x1, y1, x1 + 1, y1, x1 + 2, y1 + 1);  // near-flat
            3, 4: begin
                span = 1 << $urandom_range(1, 6);
                send_request(x1, y1, x1 + $urandom_range(span), y1 + $urandom_range(span),
                             x1 - $urandom_range(span), y1 + $urandom_range(span));
            end
            default: send_request(x1, y1, rand_coord(), rand_coord(),
                                  rand_coord(), rand_coord());
        endcase
    endtask

    task automatic drain();
        start <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, collinear, coincident, both windings, thin triangles
        send_request(-1024, -1024, 1023, -1024, -1024, 1023);
        send_request(1023, 1023, -1024, 1023, 1023, -1024);
        send_request(0, 0, 0, 0, 0, 0);
        send_request(5, 5, 5, 5, 9, -3);
        send_request(-1024, -1024, 0, 0, 1023, 1023);
        send_request(0, 0, 1, 0, 0, 1);
        send_request(0, 0, 0, 1, 1, 0);
        send_request(-1024, 0, 0, 1, 1023, 0);
        send_request(-1024, -1024, 1023, -1023, 1023, -1022);   // thin triangle
        send_request(1023, 1023, -1024, 1022, -1024, 1021);
        send_request(0, -1024, 1, 1023, 0, 1023);
        send_request(-1, -1, 1, 1, -1, 1);
        send_request(1023, 0, 0, 1023, -1024, 0);
        send_request(0, 0, 1, 1, 2, 0);
        send_request(0, 0, 1, -1, 2, 0);

        // pause until every expected result has arrived
        drain();

        for (int i = 0; i < N_RANDOM; i++) begin
            case (i / 120)
                0: idle_pct = 0;
                1: idle_pct = 49;
                2: idle_pct = 21;
                3: idle_pct = 0;
                default: idle_pct = 49;
            endcase
            if (i == 300) drain();
            send_random();
        end
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: sim.f
rtl/ccirc_pkg.sv
rtl/circumcircle_from_three_points.sv
tb/tb_circumcircle_from_three_points.sv
